@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/rlt_pkg.sv @@
`default_nettype none
package rlt_pkg;

  localparam int MaxTextLen  = 4096;
  localparam int NumberWidth = 32;
  localparam int TextLenW    = $clog2(MaxTextLen);
  localparam int NumKw       = 15;
  localparam int KwMaxLen    = 17;
  localparam int KwPosW      = 5;

  typedef enum logic [3:0] {
    K_ERROR    = 4'd0,
    K_ENDED    = 4'd1,
    K_EOL      = 4'd2,
    K_LPAREN   = 4'd3,
    K_RPAREN   = 4'd4,
    K_SPACE    = 4'd5,
    K_STAR     = 4'd6,
    K_NUMBER   = 4'd7,
    K_STRBYTE  = 4'd8,
    K_STREND   = 4'd9,
    K_KEYWORD  = 4'd10
  } kind_t;

  typedef enum logic [10:0] {
    M_NORMAL     = 11'b000_0000_0001,
    M_ATOM       = 11'b000_0000_0010,
    M_NUMBER     = 11'b000_0000_0100,
    M_QSTR       = 11'b000_0000_1000,
    M_LITNUM     = 11'b000_0001_0000,
    M_LITBRACE   = 11'b000_0010_0000,
    M_LITCR      = 11'b000_0100_0000,
    M_LITDATA    = 11'b000_1000_0000,
    M_CR         = 11'b001_0000_0000,
    M_RECOVER    = 11'b010_0000_0000,
    M_RECOVER_CR = 11'b100_0000_0000
  } mode_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    kind_t                  kind;
    logic [NumberWidth-1:0] value;
    logic [3:0]             keyword_index;
    logic                   last;
  } out_word_t;

  // Byte at a position of a keyword, 0 beyond its end.
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [KwPosW-1:0] p);
    string s;
    unique case (k)
      4'd0:  s = "ok";
      4'd1:  s = "no";
      4'd2:  s = "bye";
      4'd3:  s = "active";
      4'd4:  s = "referral";
      4'd5:  s = "sasl";
      4'd6:  s = "quota/maxscripts";
      4'd7:  s = "quota/maxsize";
      4'd8:  s = "quota";
      4'd9:  s = "transition-needed";
      4'd10: s = "trylater";
      4'd11: s = "nonexistent";
      4'd12: s = "alreadyexists";
      4'd13: s = "warning";
      4'd14: s = "tag";
      default: s = "";
    endcase
    if (int'(p) < s.len()) kw_char = s[p];
    else kw_char = 8'd0;
  endfunction

  function automatic logic [KwPosW-1:0] kw_len(input logic [3:0] k);
    unique case (k)
      4'd0, 4'd1:          kw_len = 5'd2;
      4'd2, 4'd14:         kw_len = 5'd3;
      4'd3:                kw_len = 5'd6;
      4'd4, 4'd10:         kw_len = 5'd8;
      4'd5:                kw_len = 5'd4;
      4'd6:                kw_len = 5'd16;
      4'd7, 4'd12:         kw_len = 5'd13;
      4'd8:                kw_len = 5'd5;
      4'd9:                kw_len = 5'd17;
      4'd11:               kw_len = 5'd11;
      4'd13:               kw_len = 5'd7;
      default:             kw_len = 5'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/rlt_if.sv @@
`default_nettype none
interface rlt_in_if;
  import rlt_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;
  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface rlt_out_if;
  import rlt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [3:0]             kind;
  logic [NumberWidth-1:0] value;
  logic [3:0]             keyword_index;
  logic                   last;
  modport source (output valid, output kind, output value, output keyword_index,
                  output last, input ready);
  modport sink (input valid, input kind, input value, input keyword_index,
                input last, output ready);
endinterface
`default_nettype wire

@@ rtl/rlt_front.sv @@
`default_nettype none
// Two-entry skid buffer that takes words from the input channel.
module rlt_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  rlt_in_if.sink             in_ch,
  output rlt_pkg::in_word_t  q_word,
  output logic               q_valid,
  input  wire                logic q_pop
);
  import rlt_pkg::*;

  in_word_t   buf_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push    = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_word  = buf_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ (q_pop && q_valid);
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) buf_r[wr_r] <= '{byte_in: in_ch.byte_in, end_of_input: in_ch.end_of_input};
  end
endmodule
`default_nettype wire

@@ rtl/rlt_back.sv @@
`default_nettype none
// Lexer state machine. Each queued word takes one pass; a byte
// that closes a number or keyword takes a second pass. Results go through a
// two-deep output queue, and a word is only taken when both slots are free
// enough for the worst case.
module rlt_back (
  input  wire               logic clk,
  input  wire               logic rst_n,
  input  wire               rlt_pkg::in_word_t q_word,
  input  wire               logic q_valid,
  output logic              q_pop,
  rlt_out_if.source         out_ch
);
  import rlt_pkg::*;

  mode_t                  mode_r, mode_nxt;
  logic [NumberWidth-1:0] acc_r, acc_nxt;
  logic [TextLenW-1:0]    tlen_r, tlen_nxt;
  logic [NumKw-1:0]       cand_r, cand_nxt;
  logic                   esc_r, esc_nxt;
  logic                   pass2_r, pass2_nxt;

  out_word_t  oq_r [2];
  logic       ord_r, owr_r;
  logic [1:0] ocnt_r;

  out_word_t  res;
  logic       emit, again, fire, opop;
  logic [7:0] c, lc;
  logic       is_alpha, is_digit;
  logic       p2_quiet;
  logic [3:0] d;
  logic [NumberWidth+3:0] prod;
  logic       ovf;
  logic       kw_hit;
  logic [3:0] kw_idx;

  assign c        = q_word.byte_in;
  assign is_alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  assign is_digit = (c >= "0" && c <= "9");
  assign lc       = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  assign d        = c[3:0] - 4'd0;

  // The second pass runs in normal mode, where only a letter, a digit, a quote,
  // an opening brace or a CR give no token.
  assign p2_quiet = is_alpha || is_digit || c == 8'h22 || c == 8'h7b || c == 8'h0d;

  // Pass one may give a word up to two results here (a literal close); the second pass gives one more.
  assign fire  = q_valid && (ocnt_r == 2'd0 || (ocnt_r == 2'd1 && opop) || pass2_r);
  assign q_pop = fire && !again;
  assign opop  = out_ch.valid && out_ch.ready;

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int i = NumKw - 1; i >= 0; i--) begin
      if (cand_r[i] && {{(TextLenW-KwPosW){1'b0}}, kw_len(4'(i))} == tlen_r) begin
        kw_hit = 1'b1;
        kw_idx = 4'(i);
      end
    end
  end

  // The spare top bits of the product show a value past the number width.
  always_comb begin
    prod = {4'b0000, acc_r} * (NumberWidth+4)'(10) + (NumberWidth+4)'(d);
    ovf  = |prod[NumberWidth+3:NumberWidth];
  end

  task automatic do_fail();
    emit     = 1'b1;
    res.kind = K_ERROR;
    esc_nxt  = 1'b0;
    mode_nxt = (c == 8'h0d) ? M_RECOVER_CR : M_RECOVER;
  endtask

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    tlen_nxt = tlen_r;
    cand_nxt = cand_r;
    esc_nxt  = esc_r;
    emit     = 1'b0;
    again    = 1'b0;
    res      = '{kind: K_ERROR, value: '0, keyword_index: '0, last: 1'b1};
    if (q_word.end_of_input) begin
      emit     = 1'b1;
      res.kind = K_ENDED;
    end else begin
      unique case (mode_r)
        M_RECOVER: if (c == 8'h0d) mode_nxt = M_RECOVER_CR;
        M_RECOVER_CR: begin
          if (c == 8'h0a) mode_nxt = M_NORMAL;
          emit = 1'b1; res.kind = K_EOL;
        end
        M_CR: begin
          if (c == 8'h0a) begin
            mode_nxt = M_NORMAL; emit = 1'b1; res.kind = K_EOL;
          end else do_fail();
        end
        M_QSTR: begin
          if (esc_r) begin
            if (c != 8'h22 && c != 8'h5c) do_fail();
            else begin
              esc_nxt = 1'b0; tlen_nxt = tlen_r + TextLenW'(1);
              emit = 1'b1; res.kind = K_STRBYTE; res.value = NumberWidth'(c);
            end
          end else if (c == 8'h22) begin
            mode_nxt = M_NORMAL; emit = 1'b1; res.kind = K_STREND;
          end else if (c == 8'h00 || c > 8'h7f || tlen_r >= TextLenW'(MaxTextLen - 1)) begin
            do_fail();
          end else if (c == 8'h5c) begin
            esc_nxt = 1'b1;
          end else begin
            tlen_nxt = tlen_r + TextLenW'(1);
            emit = 1'b1; res.kind = K_STRBYTE; res.value = NumberWidth'(c);
          end
        end
        M_LITNUM: begin
          if (is_digit) begin
            if (ovf) do_fail(); else acc_nxt = prod[NumberWidth-1:0];
          end else if (c == 8'h7d) mode_nxt = M_LITBRACE;
          else do_fail();
        end
        M_LITBRACE: if (c == 8'h0d) mode_nxt = M_LITCR; else do_fail();
        M_LITCR: begin
          if (c != 8'h0a) do_fail();
          else if (acc_r == '0) begin
            mode_nxt = M_NORMAL; emit = 1'b1; res.kind = K_STREND;
          end else mode_nxt = M_LITDATA;
        end
        M_LITDATA: begin
          emit = 1'b1; res.kind = K_STRBYTE; res.value = NumberWidth'(c);
          if (acc_r != '0) acc_nxt = acc_r - NumberWidth'(1);
          // The closing strend is a second result of the same word.
          if (acc_r <= NumberWidth'(1)) begin
            mode_nxt = M_NORMAL; res.last = 1'b0;
          end
        end
        M_NUMBER: begin
          if (is_digit) begin
            if (ovf) do_fail(); else acc_nxt = prod[NumberWidth-1:0];
          end else begin
            emit = 1'b1; res.kind = K_NUMBER; res.value = acc_r; res.last = p2_quiet;
            mode_nxt = M_NORMAL; again = 1'b1;
          end
        end
        M_ATOM: begin
          if (!(is_alpha || c == 8'h2f || c == 8'h2d)) begin
            if (kw_hit) begin
              emit = 1'b1; res.kind = K_KEYWORD; res.keyword_index = kw_idx;
              res.last = p2_quiet; mode_nxt = M_NORMAL; again = 1'b1;
            end else do_fail();
          end else if (tlen_r >= TextLenW'(MaxTextLen - 1)) begin
            do_fail();
          end else begin
            for (int i = 0; i < NumKw; i++)
              if (tlen_r >= TextLenW'(KwMaxLen) ||
                  kw_char(4'(i), tlen_r[KwPosW-1:0]) != lc)
                cand_nxt[i] = 1'b0;
            tlen_nxt = tlen_r + TextLenW'(1);
          end
        end
        default: begin
          mode_nxt = M_NORMAL;
          if (is_alpha) begin
            mode_nxt = M_ATOM;
            for (int i = 0; i < NumKw; i++)
              cand_nxt[i] = (kw_char(4'(i), '0) == lc);
            tlen_nxt = TextLenW'(1);
          end else if (is_digit) begin
            acc_nxt = NumberWidth'(d); mode_nxt = M_NUMBER;
          end else begin
            case (c)
              8'h28: begin emit = 1'b1; res.kind = K_LPAREN; end
              8'h29: begin emit = 1'b1; res.kind = K_RPAREN; end
              8'h20: begin emit = 1'b1; res.kind = K_SPACE; end
              8'h2a: begin emit = 1'b1; res.kind = K_STAR; end
              8'h22: begin mode_nxt = M_QSTR; tlen_nxt = '0; esc_nxt = 1'b0; end
              8'h7b: begin acc_nxt = '0; mode_nxt = M_LITNUM; end
              8'h0d: mode_nxt = M_CR;
              8'h0a: begin emit = 1'b1; res.kind = K_EOL; end
              default: do_fail();
            endcase
          end
        end
      endcase
    end
    pass2_nxt = fire ? again : pass2_r;
  end

  // Literal close pushes strbyte and strend together.
  logic dbl;
  assign dbl = fire && !q_word.end_of_input && mode_r == M_LITDATA && acc_r <= NumberWidth'(1);

  assign out_ch.valid         = (ocnt_r != 2'd0);
  assign out_ch.kind          = oq_r[ord_r].kind;
  assign out_ch.value         = oq_r[ord_r].value;
  assign out_ch.keyword_index = oq_r[ord_r].keyword_index;
  assign out_ch.last          = oq_r[ord_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_NORMAL;
      acc_r   <= '0;
      tlen_r  <= '0;
      cand_r  <= '1;
      esc_r   <= 1'b0;
      pass2_r <= 1'b0;
      ord_r   <= 1'b0;
      owr_r   <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      if (fire) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
        tlen_r <= tlen_nxt;
        cand_r <= cand_nxt;
        esc_r  <= esc_nxt;
      end
      pass2_r <= pass2_nxt;
      ord_r   <= ord_r ^ opop;
      if (dbl) begin
        owr_r <= owr_r;
        oq_r[owr_r]  <= res;
        oq_r[~owr_r] <= '{kind: K_STREND, value: '0, keyword_index: '0, last: 1'b1};
        ocnt_r <= ocnt_r + 2'd2 - {1'b0, opop};
      end else begin
        if (fire && emit) begin
          oq_r[owr_r] <= res;
          owr_r <= ~owr_r;
        end
        ocnt_r <= ocnt_r + {1'b0, fire && emit} - {1'b0, opop};
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/response_line_tokenizer_unit.sv @@
// Response line tokenizer: one response byte per input word, tokens out.
// in channel: byte_in and end_of_input; out channel: kind, value,
// keyword_index and last, last marking the final token caused by a byte.
// A two-entry input queue feeds the lexer, which writes a two-entry output
// queue. An ordinary byte is handled once in the lexer; a byte that closes
// a number or keyword is handled twice. Sustained rate is one byte per
// cycle while the receiver takes each token at once and no byte needs a
// second pass; the lexer only takes a byte when the output queue can hold
// its tokens, so bytes that give a token need the queue drained at that
// rate. Reset (rst_n low, synchronous) empties both queues and returns
// the lexer to normal mode with no atom, number or string open. When the
// receiver stalls, tokens wait in the output queue, the lexer then halts
// and the input queue fills and drops ready; nothing is lost.
`default_nettype none
`include "assert_macros.svh"
module response_line_tokenizer_unit (
  input wire logic   clk,
  input wire logic   rst_n,
  rlt_in_if.sink     in_ch,
  rlt_out_if.source  out_ch
);
  import rlt_pkg::*;

  in_word_t q_word;
  logic     q_valid, q_pop;

  rlt_front u_front (.clk, .rst_n, .in_ch, .q_word, .q_valid, .q_pop);
  rlt_back  u_back (.clk, .rst_n, .q_word, .q_valid, .q_pop, .out_ch);

  `ASSERT_IMPL(a_pop_valid, clk, rst_n, q_pop, q_valid)
  `ASSERT_IMPL(a_kind_range, clk, rst_n, out_ch.valid, out_ch.kind <= 4'd10)
  `ASSERT_IMPL(a_pass2, clk, rst_n, u_back.pass2_r, q_valid)
endmodule
`default_nettype wire
